[hw/rtl/cldev_pkg.sv]
`default_nettype none

package cldev_pkg;

  // Default number of tracked channels.
  localparam int NumChannelsDef = 16;

  // Field widths.
  localparam int ChanW   = 4;
  localparam int LevelW  = 12;
  localparam int ThrW    = 10;
  localparam int DelayW  = 20;
  localparam int TimeW   = 32;
  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;

  // Register indexes (word address paddr[3:2]).
  localparam logic [1:0] RegDevThr   = 2'd0;
  localparam logic [1:0] RegMinRef   = 2'd1;
  localparam logic [1:0] RegAlertDly = 2'd2;

  // Register reset values.
  localparam logic [ThrW-1:0]          DevThrRst   = 10'd100;
  localparam logic signed [LevelW-1:0] MinRefRst   = -12'sd400;
  localparam logic [DelayW-1:0]        AlertDlyRst = 20'd6000;

  typedef enum logic [1:0] {
    WARN_NONE  = 2'd0,
    WARN_LOUD  = 2'd1,
    WARN_QUIET = 2'd2
  } warn_e;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [ThrW-1:0]          dev_thr;
    logic signed [LevelW-1:0] min_ref;
    logic [DelayW-1:0]        alert_dly;
  } cfg_t;

  // One check transaction.
  typedef struct packed {
    logic [ChanW-1:0]         channel;
    logic                     is_monitored;
    logic                     reference_present;
    logic signed [LevelW-1:0] reference_level;
    logic signed [LevelW-1:0] channel_level;
    logic [TimeW-1:0]         now_ms;
  } item_t;

  // Per-channel tracking entry.
  typedef struct packed {
    warn_e            warning;
    logic             loud_trk;
    logic [TimeW-1:0] loud_since;
    logic             quiet_trk;
    logic [TimeW-1:0] quiet_since;
  } entry_t;

endpackage

`default_nettype wire

[hw/rtl/cldev_regs.sv]
`default_nettype none

module cldev_regs
  import cldev_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg_o
);

  logic [ThrW-1:0]          dev_thr_q;
  logic signed [LevelW-1:0] min_ref_q;
  logic [DelayW-1:0]        alert_dly_q;
  logic                     wr_en;
  logic [1:0]               reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_thr_q   <= DevThrRst;
      min_ref_q   <= MinRefRst;
      alert_dly_q <= AlertDlyRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegDevThr:   dev_thr_q   <= pwdata[ThrW-1:0];
        RegMinRef:   min_ref_q   <= pwdata[LevelW-1:0];
        RegAlertDly: alert_dly_q <= pwdata[DelayW-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      RegDevThr:   prdata = ApbDataW'(dev_thr_q);
      RegMinRef:   prdata = ApbDataW'(min_ref_q);
      RegAlertDly: prdata = ApbDataW'(alert_dly_q);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.dev_thr   = dev_thr_q;
  assign cfg_o.min_ref   = min_ref_q;
  assign cfg_o.alert_dly = alert_dly_q;

endmodule

`default_nettype wire

[hw/rtl/cldev_state.sv]
`default_nettype none

module cldev_state
  import cldev_pkg::*;
#(
  parameter int NumChannels = NumChannelsDef,
  localparam int IdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            rd_en_i,
  input  wire logic [IdxW-1:0] rd_addr_i,
  output entry_t               rd_data_o,
  input  wire logic            wr_en_i,
  input  wire logic [IdxW-1:0] wr_addr_i,
  input  wire entry_t          wr_data_i
);

  entry_t               mem [NumChannels];
  logic [NumChannels-1:0] vld_q;
  entry_t               rd_q;
  logic                 rd_vld_q;
  logic                 byp_q;
  entry_t               byp_data_q;

  // Entry storage, no reset; valid bits stand in for the cleared state.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  // Valid bits and forwarding flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
        byp_q    <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  // A write to the same entry in the read cycle wins over the stale read.
  always_comb begin
    if (byp_q) begin
      rd_data_o = byp_data_q;
    end else if (rd_vld_q) begin
      rd_data_o = rd_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cldev_eval.sv]
`default_nettype none

module cldev_eval
  import cldev_pkg::*;
#(
  parameter int NumChannels = NumChannelsDef
) (
  input  wire item_t  item_i,
  input  wire entry_t entry_i,
  input  wire cfg_t   cfg_i,
  output entry_t      entry_o,
  output logic        wr_en_o,
  output warn_e       warning_o
);

  logic signed [LevelW:0]   diff;
  logic signed [LevelW+1:0] thr_s;
  logic                     in_range;
  logic                     ok;
  logic                     is_loud;
  logic                     is_quiet;
  logic [TimeW-1:0]         loud_since;
  logic [TimeW-1:0]         quiet_since;
  logic [TimeW-1:0]         loud_elapsed;
  logic [TimeW-1:0]         quiet_elapsed;
  logic [TimeW-1:0]         dly;
  entry_t                   nxt;

  assign in_range = 32'(item_i.channel) < 32'(NumChannels);
  assign ok       = item_i.reference_present & item_i.is_monitored;

  // Level compare against the reference.
  assign diff     = (LevelW+1)'(item_i.channel_level) - (LevelW+1)'(item_i.reference_level);
  assign thr_s    = $signed({4'b0, cfg_i.dev_thr});
  assign is_loud  = (LevelW+2)'(diff) > thr_s;
  assign is_quiet = ((LevelW+2)'(-diff) > thr_s) &&
                    (item_i.reference_level >= cfg_i.min_ref);

  // Persistence timing, wrapping subtraction.
  assign loud_since    = entry_i.loud_trk  ? entry_i.loud_since  : item_i.now_ms;
  assign quiet_since   = entry_i.quiet_trk ? entry_i.quiet_since : item_i.now_ms;
  assign loud_elapsed  = item_i.now_ms - loud_since;
  assign quiet_elapsed = item_i.now_ms - quiet_since;
  assign dly           = TimeW'(cfg_i.alert_dly);

  // Next entry.
  always_comb begin
    nxt = '0;
    priority if (!ok) begin
      nxt = '0;
    end else if (is_loud) begin
      nxt.warning    = (loud_elapsed >= dly) ? WARN_LOUD : entry_i.warning;
      nxt.loud_trk   = 1'b1;
      nxt.loud_since = loud_since;
    end else if (is_quiet) begin
      nxt.warning     = (quiet_elapsed >= dly) ? WARN_QUIET : entry_i.warning;
      nxt.quiet_trk   = 1'b1;
      nxt.quiet_since = quiet_since;
    end else begin
      nxt = '0;
    end
  end

  assign entry_o   = nxt;
  assign wr_en_o   = in_range;
  assign warning_o = in_range ? nxt.warning : WARN_NONE;

endmodule

`default_nettype wire

[hw/rtl/channel_level_deviation_alarm.sv]
// Channel level deviation alarm.
// Each input transaction is one periodic level check of one channel; each
// produces exactly one output transaction carrying the channel index and the
// channel's warning state after the check (none, too loud, too quiet).
// Both channels use valid/ready handshakes. Configuration (threshold,
// minimum reference level, alert delay) is written over the APB port at
// word addresses 0, 4 and 8; the user must write it only while no
// transaction is in flight, as the block itself does not enforce this.
// The accepting edge registers the transaction together with the channel's
// entry read from the state memory; once the output register is free, the
// entry write-back and the output register load happen at the same edge.
// Throughput: one transaction per cycle while the output is not stalled; a
// write to the same channel in the cycle of the next read is forwarded, so
// back-to-back checks of one channel see current state.
// Reset clears all channel entries at once through per-entry valid bits and
// restores register defaults; no clearing pass is needed.
// When the receiver stalls, the output register holds its result and the
// evaluation stage keeps one more transaction; input ready drops only when
// both are full and the output is not being taken.
`default_nettype none

module channel_level_deviation_alarm
  import cldev_pkg::*;
#(
  parameter int NumChannels = NumChannelsDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [ChanW-1:0]         channel_i,
  input  wire logic                     is_monitored_i,
  input  wire logic                     reference_present_i,
  input  wire logic signed [LevelW-1:0] reference_level_i,
  input  wire logic signed [LevelW-1:0] channel_level_i,
  input  wire logic [TimeW-1:0]         now_ms_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [ChanW-1:0]              channel_out_o,
  output logic [1:0]                    warning_o,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [ApbAddrW-1:0]      paddr,
  input  wire logic [ApbDataW-1:0]      pwdata,
  output logic [ApbDataW-1:0]           prdata,
  output logic                          pready
);

  localparam int IdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  cfg_t             cfg;
  item_t            in_item;
  item_t            item_q;
  logic             s1_valid_q;
  logic             s1_valid_d;
  logic             out_valid_q;
  logic [ChanW-1:0] out_chan_q;
  warn_e            out_warn_q;
  logic             accept;
  logic             out_free;
  logic             s1_adv;
  logic [31:0]      rd_chan_ext;
  logic [31:0]      wr_chan_ext;
  entry_t           rd_entry;
  entry_t           wr_entry;
  logic             eval_wr;
  warn_e            eval_warn;

  cldev_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Handshake control.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign s1_valid_d = accept || (s1_valid_q && !s1_adv);

  assign in_item.channel           = channel_i;
  assign in_item.is_monitored      = is_monitored_i;
  assign in_item.reference_present = reference_present_i;
  assign in_item.reference_level   = reference_level_i;
  assign in_item.channel_level     = channel_level_i;
  assign in_item.now_ms            = now_ms_i;

  assign rd_chan_ext = 32'(channel_i);
  assign wr_chan_ext = 32'(item_q.channel);

  cldev_state #(
    .NumChannels(NumChannels)
  ) u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_addr_i(rd_chan_ext[IdxW-1:0]),
    .rd_data_o(rd_entry),
    .wr_en_i  (s1_adv && eval_wr),
    .wr_addr_i(wr_chan_ext[IdxW-1:0]),
    .wr_data_i(wr_entry)
  );

  cldev_eval #(
    .NumChannels(NumChannels)
  ) u_eval (
    .item_i   (item_q),
    .entry_i  (rd_entry),
    .cfg_i    (cfg),
    .entry_o  (wr_entry),
    .wr_en_o  (eval_wr),
    .warning_o(eval_warn)
  );

  // Input register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_chan_q <= item_q.channel;
      out_warn_q <= eval_warn;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign channel_out_o = out_chan_q;
  assign warning_o     = out_warn_q;

endmodule

`default_nettype wire

[tb/tb_channel_level_deviation_alarm.sv]
`timescale 1ns / 1ps

module tb_channel_level_deviation_alarm;
  import cldev_pkg::*;

  localparam int NumCh = NumChannelsDef;
  localparam int CycleLimit = 300000;

  // Tracks per-channel alarm state and holds the warnings still owed by the block.
  class level_alarm_scoreboard;
    typedef struct packed {
      logic [ChanW-1:0] channel;
      logic [1:0]       warning;
    } alarm_result_t;

    logic [ThrW-1:0]          dev_thr;
    logic signed [LevelW-1:0] min_ref;
    logic [DelayW-1:0]        alert_dly;
    warn_e                    warn_st[NumCh];
    bit                       loud_trk[NumCh];
    logic [TimeW-1:0]         loud_since[NumCh];
    bit                       quiet_trk[NumCh];
    logic [TimeW-1:0]         quiet_since[NumCh];
    alarm_result_t            owed_warnings[$];
    int                       errors;

    function new();
      dev_thr   = DevThrRst;
      min_ref   = MinRefRst;
      alert_dly = AlertDlyRst;
      errors    = 0;
      for (int c = 0; c < NumCh; c++) begin
        clear_channel(c);
      end
    endfunction

    function void clear_channel(int c);
      warn_st[c]     = WARN_NONE;
      loud_trk[c]    = 1'b0;
      loud_since[c]  = '0;
      quiet_trk[c]   = 1'b0;
      quiet_since[c] = '0;
    endfunction

    // Registers keep only their low bits, as the hardware does.
    function void set_register(logic [1:0] idx, logic [ApbDataW-1:0] value);
      case (idx)
        RegDevThr:   dev_thr   = value[ThrW-1:0];
        RegMinRef:   min_ref   = value[LevelW-1:0];
        RegAlertDly: alert_dly = value[DelayW-1:0];
        default: ;
      endcase
    endfunction

    // Applies one accepted check and queues the warning it should produce.
    function void note_check(item_t it);
      int               c;
      int               lvl_diff;
      int               thr;
      int               ref_lvl;
      logic [TimeW-1:0] elapsed;
      alarm_result_t    res;
      c        = it.channel;
      ref_lvl  = $signed(it.reference_level);
      lvl_diff = $signed(it.channel_level) - ref_lvl;
      thr      = dev_thr;
      res.channel = it.channel;
      if (c < NumCh) begin
        if (!it.reference_present || !it.is_monitored) begin
          clear_channel(c);
        end else if (lvl_diff > thr) begin
          if (!loud_trk[c]) begin
            loud_trk[c]   = 1'b1;
            loud_since[c] = it.now_ms;
          end
          elapsed = it.now_ms - loud_since[c];
          if (elapsed >= alert_dly) begin
            warn_st[c] = WARN_LOUD;
          end
          quiet_trk[c]   = 1'b0;
          quiet_since[c] = '0;
        end else if (-lvl_diff > thr && ref_lvl >= int'($signed(min_ref))) begin
          if (!quiet_trk[c]) begin
            quiet_trk[c]   = 1'b1;
            quiet_since[c] = it.now_ms;
          end
          elapsed = it.now_ms - quiet_since[c];
          if (elapsed >= alert_dly) begin
            warn_st[c] = WARN_QUIET;
          end
          loud_trk[c]   = 1'b0;
          loud_since[c] = '0;
        end else begin
          clear_channel(c);
        end
        res.warning = warn_st[c];
      end else begin
        res.warning = WARN_NONE;
      end
      owed_warnings.push_back(res);
    endfunction

    // Compares one delivered result with the oldest owed warning.
    function void check_result(logic [ChanW-1:0] channel, logic [1:0] warning);
      alarm_result_t exp_res;
      if (owed_warnings.size() == 0) begin
        $error("unexpected result: channel_out %0d, warning %0d", channel, warning);
        errors++;
      end else begin
        exp_res = owed_warnings.pop_front();
        if (channel !== exp_res.channel) begin
          $error("channel_out: expected %0d, actual %0d", exp_res.channel, channel);
          errors++;
        end
        if (warning !== exp_res.warning) begin
          $error("warning: expected %0d, actual %0d", exp_res.warning, warning);
          errors++;
        end
      end
    endfunction

    function int pending();
      return owed_warnings.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  item_t               chk_item;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [ChanW-1:0]    channel_out_o;
  logic [1:0]          warning_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  level_alarm_scoreboard sb;
  bit                    burst_mode;
  int                    cycle_count;
  logic [TimeW-1:0]      sim_ms;

  channel_level_deviation_alarm uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .channel_i           (chk_item.channel),
    .is_monitored_i      (chk_item.is_monitored),
    .reference_present_i (chk_item.reference_present),
    .reference_level_i   (chk_item.reference_level),
    .channel_level_i     (chk_item.channel_level),
    .now_ms_i            (chk_item.now_ms),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .channel_out_o       (channel_out_o),
    .warning_o           (warning_o),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Observe both channels at each rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_check(chk_item);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_result(channel_out_o, warning_o);
      end
    end
  end

  // Mostly short idle gaps, a few long ones, none during a burst stretch.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Receiver side: random stalls between runs of readiness.
  initial begin
    int stall;
    int hold;
    out_ready_i = 1'b0;
    forever begin
      stall = pick_gap();
      hold  = $urandom_range(1, 20);
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      repeat (hold - 1) @(negedge clk_i);
    end
  end

  function automatic item_t make_check(int ch, bit mon, bit refp, int ref_lvl, int ch_lvl,
                                       logic [TimeW-1:0] t);
    item_t it;
    it.channel           = ChanW'(ch);
    it.is_monitored      = mon;
    it.reference_present = refp;
    it.reference_level   = LevelW'(ref_lvl);
    it.channel_level     = LevelW'(ch_lvl);
    it.now_ms            = t;
    return it;
  endfunction

  // Offers one check transaction and waits until it is taken.
  task automatic send_check(input item_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    chk_item   <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drops valid, then waits for every owed result plus the pipeline depth.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(input logic [1:0] idx, input logic [ApbDataW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_thresholds(input int thr, input int min_ref, input int dly,
                                input bit junk_upper);
    logic [ApbDataW-1:0] upper;
    upper = junk_upper ? $urandom() : '0;
    write_reg(RegDevThr,   {upper[ApbDataW-1:ThrW],   ThrW'(thr)});
    write_reg(RegMinRef,   {upper[ApbDataW-1:LevelW], LevelW'(min_ref)});
    write_reg(RegAlertDly, {upper[ApbDataW-1:DelayW], DelayW'(dly)});
  endtask

  // Random checks: mostly coherent level patterns on a few channels with time
  // advancing on the order of the alert delay, plus some full-range noise.
  task automatic run_random(input int count);
    item_t it;
    int    ref_lvl;
    int    ch_lvl;
    int    thr;
    int    kind;
    int    advance;
    for (int i = 0; i < count; i++) begin
      burst_mode = (i >= count / 2) && (i < count / 2 + 15);
      thr     = sb.dev_thr;
      kind    = $urandom_range(0, 9);
      ref_lvl = $urandom_range(0, 1800) - 1600;
      if ($urandom_range(0, 9) < 2) begin
        ref_lvl = $signed(sb.min_ref) + $urandom_range(0, 2) - 1;
      end
      case (kind)
        0, 1, 2, 3: ch_lvl = ref_lvl + thr + $urandom_range(1, 60);
        4, 5, 6:    ch_lvl = ref_lvl - thr - $urandom_range(1, 60);
        7:          ch_lvl = ($urandom_range(0, 1) != 0) ? ref_lvl + thr : ref_lvl - thr;
        8:          ch_lvl = ref_lvl;
        default: begin
          ref_lvl = $urandom_range(0, 4095);
          ch_lvl  = $urandom_range(0, 4095);
        end
      endcase
      advance = $urandom_range(0, sb.alert_dly / 3 + 2);
      if ($urandom_range(0, 19) == 0) begin
        sim_ms = $urandom();
      end else begin
        sim_ms = sim_ms + advance;
      end
      it = make_check(($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 15),
                      $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                      ref_lvl, ch_lvl, sim_ms);
      send_check(it);
    end
    burst_mode = 1'b0;
  endtask

  // Main sequence.
  initial begin
    sb          = new();
    burst_mode  = 1'b0;
    cycle_count = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    chk_item    = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    sim_ms      = 32'd1000;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed checks at reset thresholds: 100 tenths, -400 reference, 6000 ms.
    // Too loud starts, then persists long enough to warn.
    send_check(make_check(0, 1, 1, -200, 0, 32'd1000));
    send_check(make_check(0, 1, 1, -200, 0, 32'd7000));
    // Too quiet starts while the loud warning remains, then takes over.
    send_check(make_check(0, 1, 1, -200, -400, 32'd8000));
    send_check(make_check(0, 1, 1, -200, -400, 32'd14000));
    // A difference exactly at the threshold counts as OK and clears.
    send_check(make_check(0, 1, 1, -200, -100, 32'd15000));
    // Quiet with a reference below the minimum clears.
    send_check(make_check(1, 1, 1, -500, -900, 32'd15000));
    // Quiet with the reference exactly at the minimum, across the time wrap.
    send_check(make_check(1, 1, 1, -400, -600, 32'hFFFF_F000));
    send_check(make_check(1, 1, 1, -400, -600, 32'h0000_0770));
    // Unmonitored channel clears its warning.
    send_check(make_check(1, 0, 1, -400, -600, 32'h0000_0800));
    // Missing reference clears tracking.
    send_check(make_check(2, 1, 1, -300, 0, 32'd100));
    send_check(make_check(2, 1, 0, -300, 0, 32'd200));
    send_check(make_check(2, 1, 1, -300, 0, 32'd6099));
    // Extreme field values.
    send_check(make_check(15, 1, 1, -2048, 2047, 32'hFFFF_FFFF));
    send_check(make_check(15, 1, 1, 2047, -2048, 32'h0000_0000));
    send_check(make_check(8, 1, 1, -1600, 200, 32'h8000_0000));
    send_check(make_check(10, 1, 1, 200, -1600, 32'h5555_5555));
    send_check(make_check(5, 1, 1, 200, -1600, 32'hAAAA_AAAA));
    send_check(make_check(10, 0, 0, 0, 0, 32'h0000_0001));
    sim_ms = 32'd20000;
    run_random(90);
    drain();

    // Zero threshold, lowest reference, no delay; random upper register bits.
    set_thresholds(0, -1600, 0, 1'b1);
    send_check(make_check(3, 1, 1, -100, -100, 32'd5));
    send_check(make_check(3, 1, 1, -100, -99, 32'd5));
    send_check(make_check(3, 1, 1, -100, -101, 32'd5));
    run_random(70);
    drain();

    // Upper end of the documented ranges.
    set_thresholds(600, 200, 600000, 1'b0);
    sim_ms = 32'hFFF0_0000;
    run_random(80);
    drain();

    // All-ones threshold and delay, most negative minimum reference.
    set_thresholds(1023, -2048, 20'hFFFFF, 1'b1);
    run_random(60);
    drain();

    // Random middle settings.
    set_thresholds($urandom_range(0, 600), $urandom_range(0, 1800) - 1600,
                   $urandom_range(0, 20000), 1'b0);
    run_random(90);
    drain();

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
